[rtl/core/aphc_pkg.sv]
// Shared types, opcode constants and word decode functions for the ARM64
// prologue hook classifier. No dependencies; the decode, score, top and testbench files import it.
`default_nettype none

package aphc_pkg;

    // Each window carries eight 32-bit instruction words.
    localparam int AVAIL_WORDS      = 8;
    localparam int DEF_WINDOW_WORDS = 8;

    typedef logic [31:0]                   t_word;
    typedef logic [AVAIL_WORDS-1:0][31:0]  t_window;
    typedef logic signed [25:0]            t_imm;
    typedef logic [3:0]                    t_score;

    // Confidence codes.
    typedef enum logic [1:0] {
        CONF_NONE   = 2'd0,
        CONF_LOW    = 2'd1,
        CONF_MEDIUM = 2'd2,
        CONF_HIGH   = 2'd3
    } t_conf;

    // Opcodes and their masks.
    localparam t_word OP_NOP  = 32'hD503_201F;
    localparam t_word M_SVC   = 32'hFFE0_001F;
    localparam t_word OP_SVC  = 32'hD400_0001;
    localparam t_word M_B     = 32'hFC00_0000;
    localparam t_word OP_B    = 32'h1400_0000;
    localparam t_word OP_BL   = 32'h9400_0000;
    localparam t_word M_BR    = 32'hFFFF_FC1F;
    localparam t_word OP_BR   = 32'hD61F_0000;
    localparam t_word OP_BLR  = 32'hD63F_0000;
    localparam t_word OP_RET  = 32'hD65F_03C0;
    localparam t_word M_ADRP  = 32'h9F00_0000;
    localparam t_word OP_ADRP = 32'h9000_0000;
    localparam t_word M_LDR   = 32'hFFC0_0000;
    localparam t_word OP_LDR  = 32'hF940_0000;
    localparam t_word M_MOVZ  = 32'hFFE0_0000;
    localparam t_word OP_MOVZ = 32'hD280_0000;

    // Branch offset limits, expressed on imm26 (byte offset divided by four).
    localparam t_imm IMM_ZERO     = 26'sd0;
    localparam t_imm IMM_WRAP_LIM = 26'sd16384;     // 0x10000 bytes
    localparam t_imm IMM_TAIL_LIM = 26'sd128;       // 0x200 bytes
    localparam t_imm IMM_NEAR_POS = 26'sd1024;      // 0x1000 bytes
    localparam t_imm IMM_NEAR_NEG = -26'sd1024;
    localparam t_imm IMM_FAR_POS  = 26'sd262144;    // 0x100000 bytes
    localparam t_imm IMM_FAR_NEG  = -26'sd262144;

    // Score weights.
    localparam t_score SC_SVC      = 4'd3;
    localparam t_score SC_B_FAR    = 4'd3;
    localparam t_score SC_B_NEAR   = 4'd1;
    localparam t_score SC_INDIRECT = 4'd2;
    localparam t_score SC_CALL     = 4'd2;
    localparam t_score SC_NONE     = 4'd0;

    // Decoded flags carried from the decode stage to the scoring stage.
    typedef struct packed {
        logic d_syscall;   // NOP, MOVZ, SVC stub on disk
        logic d_plt;       // ADRP then LDR on disk
        logic d_wrap;      // short forward B on disk
        logic d_b;
        logic d_nop;
        logic d_bl;
        logic d_ind;
        logic m_b;
        logic m_tail;      // backward or very short forward B in memory
        logic m_near;      // nonzero B within 0x1000 bytes in memory
        logic m_far;       // B beyond 0x100000 bytes in memory
        logic m_bl;
        logic m_ind;
        logic m_ret;       // RET in the first four live words
        logic d_svc;
        logic m_svc;
    } t_dec;

    function automatic logic is_b(input t_word w);
        return (w & M_B) == OP_B;
    endfunction

    function automatic logic is_bl(input t_word w);
        return (w & M_B) == OP_BL;
    endfunction

    function automatic logic is_svc(input t_word w);
        return (w & M_SVC) == OP_SVC;
    endfunction

    function automatic logic is_indirect(input t_word w);
        return ((w & M_BR) == OP_BR) || ((w & M_BR) == OP_BLR);
    endfunction

    function automatic t_imm br_imm(input t_word w);
        return t_imm'(w[25:0]);
    endfunction

endpackage

`default_nettype wire

[rtl/core/aphc_decode.sv]
// First pipeline stage: decodes both instruction windows into a flag set.
// Depends on aphc_pkg.
`default_nettype none

module aphc_decode
    import aphc_pkg::*;
#(
    parameter int WINDOW_WORDS = DEF_WINDOW_WORDS
)
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_window i_disk,
    input  wire t_window i_live,
    output logic         o_valid,
    output t_dec         o_dec
);

    // The SVC scan never reaches past the words that the input carries.
    localparam int SCAN_WORDS = (WINDOW_WORDS < AVAIL_WORDS) ? WINDOW_WORDS : AVAIL_WORDS;

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;
    t_imm w_dimm;
    t_imm w_mimm;

    // Per-word pattern tests; the SVC scans cover independent words.
    always_comb begin
        w_dimm = br_imm(i_disk[0]);
        w_mimm = br_imm(i_live[0]);

        n_dec.d_syscall = (i_disk[0] == OP_NOP) && ((i_disk[1] & M_MOVZ) == OP_MOVZ)
                          && is_svc(i_disk[2]);
        n_dec.d_plt     = ((i_disk[0] & M_ADRP) == OP_ADRP)
                          && ((i_disk[1] & M_LDR) == OP_LDR);
        n_dec.d_b       = is_b(i_disk[0]);
        n_dec.d_wrap    = is_b(i_disk[0]) && (w_dimm > IMM_ZERO) && (w_dimm < IMM_WRAP_LIM);
        n_dec.d_nop     = i_disk[0] == OP_NOP;
        n_dec.d_bl      = is_bl(i_disk[0]);
        n_dec.d_ind     = is_indirect(i_disk[0]);

        n_dec.m_b       = is_b(i_live[0]);
        n_dec.m_tail    = (w_mimm < IMM_ZERO)
                          || ((w_mimm > IMM_ZERO) && (w_mimm < IMM_TAIL_LIM));
        n_dec.m_near    = ((w_mimm > IMM_ZERO) && (w_mimm < IMM_NEAR_POS))
                          || ((w_mimm < IMM_ZERO) && (w_mimm > IMM_NEAR_NEG));
        n_dec.m_far     = (w_mimm > IMM_FAR_POS) || (w_mimm < IMM_FAR_NEG);
        n_dec.m_bl      = is_bl(i_live[0]);
        n_dec.m_ind     = is_indirect(i_live[0]);

        n_dec.m_ret     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (i_live[i] == OP_RET) begin
                n_dec.m_ret = 1'b1;
            end
        end

        n_dec.d_svc = 1'b0;
        n_dec.m_svc = 1'b0;
        for (int i = 0; i < SCAN_WORDS; i++) begin
            if (is_svc(i_disk[i])) begin
                n_dec.d_svc = 1'b1;
            end
            if (is_svc(i_live[i])) begin
                n_dec.m_svc = 1'b1;
            end
        end
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

[rtl/core/aphc_score.sv]
// Second and third pipeline stages: benign filters and score sum, then the
// mapping to a confidence level. Depends on aphc_pkg.
`default_nettype none

module aphc_score
    import aphc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_dec  i_dec,
    output logic       o_valid,
    output t_conf      o_conf
);

    logic   r_valid2;
    logic   r_benign;
    t_score r_score;
    logic   n_benign;
    t_score n_score;
    logic   w_svc_rm;
    logic   w_b_add;
    logic   r_valid3;
    t_conf  r_conf;
    t_conf  n_conf;

    // Benign filters and score terms. The alternative-implementation filter
    // needs a RET in the first three live words, which the early-return
    // filter already catches, so it is not built.
    always_comb begin
        w_svc_rm = i_dec.d_svc && !i_dec.m_svc;
        w_b_add  = i_dec.m_b && !i_dec.d_b && !i_dec.d_nop && !i_dec.d_plt;

        n_benign = i_dec.d_syscall || i_dec.d_plt || i_dec.d_wrap
                   || (i_dec.m_b && i_dec.m_tail) || i_dec.m_ret
                   || (w_svc_rm && i_dec.m_b && i_dec.m_near);

        n_score = (w_svc_rm ? SC_SVC : SC_NONE)
                  + (w_b_add ? (i_dec.m_far ? SC_B_FAR : SC_B_NEAR) : SC_NONE)
                  + ((i_dec.m_ind && !i_dec.d_ind) ? SC_INDIRECT : SC_NONE)
                  + ((i_dec.m_bl && !i_dec.d_bl) ? SC_CALL : SC_NONE);
    end

    // Saturate the score into a confidence level; a benign item maps to none.
    always_comb begin
        if (r_benign) begin
            n_conf = CONF_NONE;
        end else if (r_score >= 4'd3) begin
            n_conf = CONF_HIGH;
        end else begin
            n_conf = t_conf'(r_score[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
        r_benign <= n_benign;
        r_score  <= n_score;
        r_conf   <= n_conf;
    end

    assign o_valid = r_valid3;
    assign o_conf  = r_conf;

endmodule

`default_nettype wire

[rtl/core/arm64_patch_hook_classifier_top.sv]
// A result strobes once its item has passed the decode, score and map registers.
// Throughput: one item per cycle once busy is low; three register stages, decode, score, map.
// busy is high during reset and until the ready flag is set, then stays low.
// Reset is synchronous, active low, and clears the ready flag and the stage valid bits.
// Depends on aphc_pkg, aphc_decode and aphc_score.
`default_nettype none

module arm64_patch_hook_classifier_top
    import aphc_pkg::*;
#(
    parameter int WINDOW_WORDS = DEF_WINDOW_WORDS
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_disk_words_0_1,
    input  wire logic [63:0] i_disk_words_2_3,
    input  wire logic [63:0] i_disk_words_4_5,
    input  wire logic [63:0] i_disk_words_6_7,
    input  wire logic [63:0] i_live_words_0_1,
    input  wire logic [63:0] i_live_words_2_3,
    input  wire logic [63:0] i_live_words_4_5,
    input  wire logic [63:0] i_live_words_6_7,
    output logic             o_valid,
    output logic [1:0]       o_confidence
);

    logic    r_ready;
    logic    w_accept;
    t_window w_disk;
    t_window w_live;
    logic    w_dec_valid;
    t_dec    w_dec;
    t_conf   w_conf;

    // Ready is registered and goes high in the cycle after reset is released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy     = !r_ready;
    assign w_accept = start && r_ready;

    // Even words sit in the low half of each input field.
    assign w_disk = {i_disk_words_6_7, i_disk_words_4_5, i_disk_words_2_3, i_disk_words_0_1};
    assign w_live = {i_live_words_6_7, i_live_words_4_5, i_live_words_2_3, i_live_words_0_1};

    aphc_decode #(
        .WINDOW_WORDS (WINDOW_WORDS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_disk  (w_disk),
        .i_live  (w_live),
        .o_valid (w_dec_valid),
        .o_dec   (w_dec)
    );

    aphc_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .i_dec   (w_dec),
        .o_valid (o_valid),
        .o_conf  (w_conf)
    );

    assign o_confidence = w_conf;

endmodule

`default_nettype wire

[rtl/core/aphc_checker.sv]
// Port-level checks for the hook classifier top level, attached by bind.
// Depends on arm64_patch_hook_classifier_top.
`default_nettype none

module aphc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [63:0] i_disk_words_0_1,
    input wire logic [63:0] i_disk_words_2_3,
    input wire logic [63:0] i_disk_words_4_5,
    input wire logic [63:0] i_disk_words_6_7,
    input wire logic [63:0] i_live_words_0_1,
    input wire logic [63:0] i_live_words_2_3,
    input wire logic [63:0] i_live_words_4_5,
    input wire logic [63:0] i_live_words_6_7,
    input wire logic        o_valid,
    input wire logic [1:0]  o_confidence
);

    logic w_accept;
    logic w_same;

    assign w_accept = start && !busy;
    assign w_same   = (i_disk_words_0_1 == i_live_words_0_1)
                      && (i_disk_words_2_3 == i_live_words_2_3)
                      && (i_disk_words_4_5 == i_live_words_4_5)
                      && (i_disk_words_6_7 == i_live_words_6_7);

    // Once out of reset the block never refuses a transfer.
    a_never_busy: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) |-> !busy)
        else $error("busy high after reset completed");

    // Every accepted item yields a result through the decode, score and map stages.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_valid)
        else $error("accepted item produced no result");

    // No result appears without an earlier accepted item.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 3))
        else $error("result without an accepted item");

    // An unmodified prologue can never be reported as hooked.
    a_same_is_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(w_accept && w_same, 3) |-> o_confidence == 2'd0)
        else $error("identical windows classified as hooked");

endmodule

bind arm64_patch_hook_classifier_top aphc_checker u_aphc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_disk_words_0_1 (i_disk_words_0_1),
    .i_disk_words_2_3 (i_disk_words_2_3),
    .i_disk_words_4_5 (i_disk_words_4_5),
    .i_disk_words_6_7 (i_disk_words_6_7),
    .i_live_words_0_1 (i_live_words_0_1),
    .i_live_words_2_3 (i_live_words_2_3),
    .i_live_words_4_5 (i_live_words_4_5),
    .i_live_words_6_7 (i_live_words_6_7),
    .o_valid          (o_valid),
    .o_confidence     (o_confidence)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for arm64_patch_hook_classifier_top: directed prologue
// pairs, then random hooked and noisy pairs, each checked against a hand-written value or a local model.
// Depends on aphc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module testbench;
    import aphc_pkg::*;

    // Ordinary prologue words used to pad directed windows.
    localparam t_word STP_FP  = 32'hA9BF7BFD;
    localparam t_word MOV_FP  = 32'h910003FD;
    localparam t_word STR_X19 = 32'hF9000BF3;
    localparam t_word MOV_X19 = 32'hAA0003F3;
    localparam t_word SUB_SP  = 32'hD10043FF;
    localparam t_word CBZ_X0  = 32'hB4000040;
    localparam int    RANDOM_ITEMS = 1725;

    typedef struct {
        t_window disk;
        t_window live;
        bit      typed;   // conf below was written by hand
        t_conf   conf;
    } t_pair;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_disk_words_0_1;
    logic [63:0] i_disk_words_2_3;
    logic [63:0] i_disk_words_4_5;
    logic [63:0] i_disk_words_6_7;
    logic [63:0] i_live_words_0_1;
    logic [63:0] i_live_words_2_3;
    logic [63:0] i_live_words_4_5;
    logic [63:0] i_live_words_6_7;
    logic        o_valid;
    logic [1:0]  o_confidence;

    t_conf conf_expected_q[$];
    t_conf staged_conf;
    t_conf due_conf;
    int    errors;

    arm64_patch_hook_classifier_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_disk_words_0_1 (i_disk_words_0_1),
        .i_disk_words_2_3 (i_disk_words_2_3),
        .i_disk_words_4_5 (i_disk_words_4_5),
        .i_disk_words_6_7 (i_disk_words_6_7),
        .i_live_words_0_1 (i_live_words_0_1),
        .i_live_words_2_3 (i_live_words_2_3),
        .i_live_words_4_5 (i_live_words_4_5),
        .i_live_words_6_7 (i_live_words_6_7),
        .o_valid          (o_valid),
        .o_confidence     (o_confidence)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Instruction decode for the prediction.
    function automatic bit is_uncond_b(input t_word w);
        return (w & M_B) == OP_B;
    endfunction

    function automatic bit is_call(input t_word w);
        return (w & M_B) == OP_BL;
    endfunction

    function automatic bit is_trap(input t_word w);
        return (w & M_SVC) == OP_SVC;
    endfunction

    function automatic bit is_reg_branch(input t_word w);
        return (w & M_BR) == OP_BR || (w & M_BR) == OP_BLR;
    endfunction

    function automatic bit plt_pair(input t_window d);
        return (d[0] & M_ADRP) == OP_ADRP && (d[1] & M_LDR) == OP_LDR;
    endfunction

    function automatic bit ret_in(input t_window m, input int n);
        int k;
        for (k = 0; k < n; k++)
            if (m[k] == OP_RET)
                return 1'b1;
        return 1'b0;
    endfunction

    // Byte offset of a B or BL word: imm26 sign-extended, times four.
    function automatic longint jump_bytes(input t_word w);
        longint v;
        v = longint'($signed(w[25:0]));
        return v * 4;
    endfunction

    // Confidence that the live window was hooked relative to the disk window.
    function automatic t_conf predict_confidence(input t_window d, input t_window m);
        longint off;
        bit     dsvc, msvc, dcode;
        int     score, k;
        dsvc  = 1'b0;
        msvc  = 1'b0;
        dcode = 1'b0;
        score = 0;
        // Benign filters, in priority order.
        if (d[0] == OP_NOP && (d[1] & M_MOVZ) == OP_MOVZ && is_trap(d[2]))
            return CONF_NONE;
        if (plt_pair(d))
            return CONF_NONE;
        if (is_uncond_b(d[0])) begin
            off = jump_bytes(d[0]);
            if (off > 0 && off < 64'sh10000)
                return CONF_NONE;
        end
        if (is_uncond_b(m[0])) begin
            off = jump_bytes(m[0]);
            if (off < 0 || (off > 0 && off < 64'sh200))
                return CONF_NONE;
        end
        if (ret_in(m, 4))
            return CONF_NONE;
        for (k = 0; k < 4; k++)
            if (d[k] != OP_NOP && d[k] != 32'h0)
                dcode = 1'b1;
        if (dcode && ret_in(m, 3))
            return CONF_NONE;
        // Findings that add to the score.
        for (k = 0; k < 8; k++) begin
            if (is_trap(d[k])) dsvc = 1'b1;
            if (is_trap(m[k])) msvc = 1'b1;
        end
        if (dsvc && !msvc) begin
            if (is_uncond_b(m[0])) begin
                off = jump_bytes(m[0]);
                if ((off > 0 && off < 64'sh1000) || (off < 0 && off > -64'sh1000))
                    return CONF_NONE;
            end
            score += 3;
        end
        if (is_uncond_b(m[0]) && !is_uncond_b(d[0]) && d[0] != OP_NOP && !plt_pair(d)) begin
            off = jump_bytes(m[0]);
            score += (off > 64'sh100000 || off < -64'sh100000) ? 3 : 1;
        end
        if (is_reg_branch(m[0]) && !is_reg_branch(d[0]))
            score += 2;
        if (is_call(m[0]) && !is_call(d[0]))
            score += 2;
        case (score)
            0:       return CONF_NONE;
            1:       return CONF_LOW;
            2:       return CONF_MEDIUM;
            default: return CONF_HIGH;
        endcase
    endfunction

    // Word builders for stimulus.
    function automatic t_word b_to(input int imm);
        return OP_B | t_word'(imm & 32'h03FF_FFFF);
    endfunction

    function automatic t_word bl_to(input int imm);
        return OP_BL | t_word'(imm & 32'h03FF_FFFF);
    endfunction

    function automatic t_word svc_word();
        return OP_SVC | (t_word'($urandom_range(0, 65535)) << 5);
    endfunction

    function automatic t_word reg_branch_word();
        return ($urandom_range(0, 1) ? OP_BR : OP_BLR) | (t_word'($urandom_range(0, 31)) << 5);
    endfunction

    // Branch immediates, mostly at the decision thresholds.
    function automatic int pick_imm();
        int v;
        case ($urandom_range(0, 15))
            0:       v = 0;
            1:       v = 1;
            2:       v = -1;
            3:       v = 127 + $urandom_range(0, 2);
            4:       v = 1023 + $urandom_range(0, 2);
            5:       v = -(1023 + $urandom_range(0, 2));
            6:       v = 16383 + $urandom_range(0, 1);
            7:       v = 262143 + $urandom_range(0, 2);
            8:       v = -(262143 + $urandom_range(0, 2));
            9:       v = 32'h01FF_FFFF;
            10:      v = -32'sh0200_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_word any_insn();
        case ($urandom_range(0, 12))
            0:       return OP_NOP;
            1:       return 32'h0;
            2:       return svc_word();
            3:       return OP_MOVZ | ($urandom & ~M_MOVZ);
            4:       return OP_ADRP | ($urandom & ~M_ADRP);
            5:       return OP_LDR | ($urandom & ~M_LDR);
            6:       return b_to(pick_imm());
            7:       return bl_to(pick_imm());
            8:       return reg_branch_word();
            9:       return OP_RET;
            default: return $urandom;
        endcase
    endfunction

    // Disk prologue with random content, and a live copy that is usually a
    // faithful or hooked version of it and sometimes plain noise.
    function automatic void build_pair(output t_window d, output t_window m);
        int k;
        for (k = 0; k < 8; k++)
            d[k] = ($urandom_range(0, 3) == 0) ? any_insn() : t_word'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                d[0] = OP_NOP;
                d[1] = OP_MOVZ | ($urandom & ~M_MOVZ);
                d[2] = svc_word();
            end
            1: begin
                d[0] = OP_ADRP | ($urandom & ~M_ADRP);
                d[1] = OP_LDR | ($urandom & ~M_LDR);
            end
            2:       d[0] = b_to(pick_imm());
            3:       d[0] = OP_NOP;
            4:       d[0] = bl_to(pick_imm());
            5:       d[0] = reg_branch_word();
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            d[$urandom_range(0, 7)] = svc_word();
        if ($urandom_range(0, 9) == 0) begin
            for (k = 0; k < 8; k++)
                m[k] = $urandom;
            return;
        end
        m = d;
        if ($urandom_range(0, 1))
            for (k = 0; k < 8; k++)
                if (is_trap(m[k]))
                    m[k] = OP_NOP;
        case ($urandom_range(0, 5))
            1, 2:    m[0] = b_to(pick_imm());
            3:       m[0] = reg_branch_word();
            4:       m[0] = bl_to(pick_imm());
            5:       m[$urandom_range(0, 3)] = OP_RET;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            m[$urandom_range(0, 7)] = $urandom;
    endfunction

    // Directed pair on a fixed prologue; only the named words differ.
    function automatic t_pair vec(input t_word d0, input t_word d1, input t_word d2,
                                  input t_word m0, input t_word m2, input t_word m3,
                                  input bit typed, input t_conf conf);
        t_pair p;
        p.disk  = {CBZ_X0, SUB_SP, STR_X19, MOV_FP, MOV_X19, d2, d1, d0};
        p.live  = {CBZ_X0, SUB_SP, STR_X19, MOV_FP, m3, m2, d1, m0};
        p.typed = typed;
        p.conf  = conf;
        return p;
    endfunction

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Present one pair after an optional gap and hold it until the transfer.
    task automatic send_pair(input t_window d, input t_window m, input bit typed,
                             input t_conf conf, input bit no_gap);
        int unsigned idle;
        idle = no_gap ? 0 : idle_cycles();
        repeat (idle) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start            <= 1'b1;
        i_disk_words_0_1 <= d[1:0];
        i_disk_words_2_3 <= d[3:2];
        i_disk_words_4_5 <= d[5:4];
        i_disk_words_6_7 <= d[7:6];
        i_live_words_0_1 <= m[1:0];
        i_live_words_2_3 <= m[3:2];
        i_live_words_4_5 <= m[5:4];
        i_live_words_6_7 <= m[7:6];
        staged_conf      <= typed ? conf : predict_confidence(d, m);
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Check each result strobe, then record the expectation of any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (conf_expected_q.size() == 0) begin
                    errors++;
                    $error("confidence: expected nothing, actual %0d", o_confidence);
                end else begin
                    due_conf = conf_expected_q.pop_front();
                    if (o_confidence !== due_conf) begin
                        errors++;
                        $error("confidence: expected %0d, actual %0d", due_conf, o_confidence);
                    end
                end
            end else if (o_valid !== 1'b0) begin
                errors++;
                $error("o_valid: expected 0 or 1, actual %b", o_valid);
            end
            if (start && busy === 1'b0)
                conf_expected_q.push_back(staged_conf);
        end
    end

    initial begin
        t_pair   directed_q[$];
        t_pair   p;
        t_window d, m;
        int      n, drain;
        errors           = 0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_disk_words_0_1 = '0;
        i_disk_words_2_3 = '0;
        i_disk_words_4_5 = '0;
        i_disk_words_6_7 = '0;
        i_live_words_0_1 = '0;
        i_live_words_2_3 = '0;
        i_live_words_4_5 = '0;
        i_live_words_6_7 = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the words, each benign filter, and each scored finding.
        p = vec(STP_FP, MOV_FP, STR_X19, STP_FP, STR_X19, MOV_X19, 1'b1, CONF_NONE);
        p.disk = '0;
        p.live = '0;
        directed_q.push_back(p);
        p.disk = '1;
        p.live = '1;
        directed_q.push_back(p);
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, STP_FP, STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        // Syscall stub, PLT stub and short wrapper on disk.
        directed_q.push_back(vec(OP_NOP, OP_MOVZ | 32'h1108, OP_SVC, bl_to(64),
                                 STR_X19, MOV_X19, 1'b1, CONF_NONE));
        directed_q.push_back(vec(OP_ADRP | 32'h10, OP_LDR | 32'h211, STR_X19, b_to(262145),
                                 STR_X19, MOV_X19, 1'b1, CONF_NONE));
        directed_q.push_back(vec(b_to(1), MOV_FP, STR_X19, bl_to(100), STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(b_to(16384), MOV_FP, STR_X19, bl_to(100), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        // Tail calls in memory.
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(-1), STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(127), STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(128), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(-32'sh0200_0000), STR_X19,
                                 MOV_X19, 1'b1, CONF_NONE));
        // Early return and alternative implementation.
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, OP_RET, STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, STP_FP, STR_X19, OP_RET,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, STP_FP, OP_RET, MOV_X19,
                                 1'b1, CONF_NONE));
        // Removed SVC, alone and with a near or just-not-near branch.
        directed_q.push_back(vec(STP_FP, MOV_FP, OP_SVC | 32'h20, STP_FP, STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, OP_SVC, b_to(512), STR_X19, MOV_X19,
                                 1'b1, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, OP_SVC, b_to(1024), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, OP_SVC, b_to(0), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        // Added branches around the far threshold and the largest offset.
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(262145), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, b_to(262144), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        directed_q.push_back(vec(OP_NOP, MOV_FP, STR_X19, b_to(32'h01FF_FFFF), STR_X19,
                                 MOV_X19, 1'b0, CONF_NONE));
        directed_q.push_back(vec(b_to(0), MOV_FP, STR_X19, b_to(0), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        // Indirect branches and calls, added or already present.
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, OP_BR | (32'd16 << 5), STR_X19,
                                 MOV_X19, 1'b0, CONF_NONE));
        directed_q.push_back(vec(OP_BLR | (32'd8 << 5), MOV_FP, STR_X19, OP_BLR | (32'd17 << 5),
                                 STR_X19, MOV_X19, 1'b0, CONF_NONE));
        directed_q.push_back(vec(STP_FP, MOV_FP, STR_X19, bl_to(-5), STR_X19, MOV_X19,
                                 1'b0, CONF_NONE));
        foreach (directed_q[i])
            send_pair(directed_q[i].disk, directed_q[i].live, directed_q[i].typed,
                      directed_q[i].conf, 1'b0);

        // Random pairs, with stretches of back-to-back transfers.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            build_pair(d, m);
            send_pair(d, m, 1'b0, CONF_NONE, (n % 200) < 40);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain the pipeline, then wait on for stray strobes.
        drain = 0;
        while (conf_expected_q.size() != 0 && drain < 64) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (conf_expected_q.size() != 0) begin
            errors++;
            $error("confidence: %0d results never arrived", conf_expected_q.size());
        end
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
